### design/pbde_pkg.sv
package pbde_pkg;

    // Generator state after reset.
    localparam logic [63:0] GEN_SEED = 64'h29D3881D58517D9D;

    // Depth of the bit queue between the front and the back.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_LVL_W = $clog2(Q_DEPTH + 1);

    // Width of the call_count result field.
    localparam int unsigned OUT_COUNT_W = 32;

    // One bit to be encoded, as handed from the front to the back.
    typedef struct packed {
        logic want;
        logic last;
    } t_bit_cmd;

    // Fill status of the bit queue.
    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_LVL_W-1:0] level;
    } t_q_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPLAY,
        ST_SEARCH,
        ST_PUSH
    } t_back_state;

    // One generator step: shift left by two, feed in the low two bits of the
    // sum of bits 61:60 and bits 5:4.
    function automatic logic [63:0] gen_next(input logic [63:0] s);
        logic [1:0] sum;
        sum = s[61:60] + s[5:4];
        return {s[61:0], sum};
    endfunction

endpackage

### design/pbde_front.sv
module pbde_front
    import pbde_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_stall_unused_guard,
    input  logic [7:0] i_data_byte,
    output logic     o_stall,
    input  logic     i_q_full,
    output logic     o_push,
    output t_bit_cmd o_cmd
);

    logic [7:0] r_bits;
    logic [3:0] r_left;
    logic [7:0] n_bits;
    logic [3:0] n_left;
    logic       accept;

    // Bits are handed out most significant first, one per cycle while the queue is not full.
    always_comb begin
        o_push     = (r_left != 4'd0) && !i_q_full;
        o_cmd.want = r_bits[7];
        o_cmd.last = (r_left == 4'd1);
        o_stall    = !((r_left == 4'd0) || ((r_left == 4'd1) && o_push))
                     || i_stall_unused_guard;
        accept     = i_valid && !o_stall;
        n_bits     = r_bits;
        n_left     = r_left;
        if (o_push) begin
            n_bits = {r_bits[6:0], 1'b0};
            n_left = r_left - 4'd1;
        end
        if (accept) begin
            n_bits = i_data_byte;
            n_left = 4'd8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 4'd0;
        end else begin
            r_left <= n_left;
        end
        r_bits <= n_bits;
    end

endmodule

### design/pbde_queue.sv
module pbde_queue
    import pbde_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_bit_cmd  i_cmd,
    input  logic      i_pop,
    output t_bit_cmd  o_cmd,
    output t_q_status o_status
);

    t_bit_cmd           r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_head;
    logic [Q_PTR_W-1:0] r_tail;
    logic [Q_LVL_W-1:0] r_level;

    always_comb begin
        o_cmd           = r_mem[r_head];
        o_status.level  = r_level;
        o_status.full   = (r_level == Q_LVL_W'(Q_DEPTH));
        o_status.empty  = (r_level == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_head <= r_head + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + Q_LVL_W'(1);
            end else if (!i_push && i_pop) begin
                r_level <= r_level - Q_LVL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_cmd;
        end
    end

endmodule

### design/pbde_back.sv
module pbde_back
    import pbde_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 32
)(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  t_bit_cmd               i_cmd,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [OUT_COUNT_W-1:0] o_call_count,
    output logic                   o_last_of_byte
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    t_back_state            r_state;
    t_back_state            n_state;
    logic [63:0]            r_gen;
    logic [63:0]            n_gen;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] r_rem;
    logic [COUNT_WIDTH-1:0] n_rem;
    logic                   r_want;
    logic                   n_want;
    logic                   r_last;
    logic                   n_last;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [OUT_COUNT_W-1:0] r_out_count;
    logic [OUT_COUNT_W-1:0] n_out_count;
    logic                   r_out_last;
    logic                   n_out_last;
    logic [63:0]            step;
    logic [63:0]            count_wide;

    always_comb begin
        step        = gen_next(r_gen);
        count_wide  = 64'(r_count);
        n_state     = r_state;
        n_gen       = r_gen;
        n_count     = r_count;
        n_rem       = r_rem;
        n_want      = r_want;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_stall;
        n_out_count = r_out_count;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_want  = i_cmd.want;
                    n_last  = i_cmd.last;
                    n_rem   = r_count;
                    n_state = (r_count == '0) ? ST_SEARCH : ST_REPLAY;
                end
            end
            ST_REPLAY: begin
                n_gen = step;
                n_rem = r_rem - COUNT_WIDTH'(1);
                if (r_rem == COUNT_WIDTH'(1)) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                n_gen = step;
                if (r_count != COUNT_MAX) begin
                    n_count = r_count + COUNT_WIDTH'(1);
                end
                if (step[1] == r_want) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_count = count_wide[OUT_COUNT_W-1:0];
                    n_out_last  = r_last;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gen       <= GEN_SEED;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gen       <= n_gen;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_rem       <= n_rem;
        r_want      <= n_want;
        r_last      <= n_last;
        r_out_count <= n_out_count;
        r_out_last  <= n_out_last;
    end

    assign o_valid        = r_out_valid;
    assign o_call_count   = r_out_count;
    assign o_last_of_byte = r_out_last;

endmodule

### design/prng_bit_distance_encoder_unit.sv
// Bit-distance encoder driven by a 64-bit two-bit-shift generator.
// Input channel: i_valid, i_data_byte and o_stall; a byte is taken at a rising
// edge where i_valid is high and o_stall is low. Output channel: o_valid,
// o_call_count, o_last_of_byte and i_stall; a result transaction completes at
// an edge where o_valid is high and i_stall is low.
// Every byte yields eight results, most significant bit first, and the eighth
// carries o_last_of_byte. The front splits a byte into bits at one per cycle,
// while the four-entry queue has room; the back replays and searches the
// generator at one step per cycle. Each bit takes a pop, a replay of C steps,
// where C is the call count before the bit, a search of S steps until the
// generator bit matches, and a push of the result, so the rate falls as the
// count grows. The single generator step unit in the back sets that rate.
// A new byte can be taken as soon as the front has handed its last bit on.
// Synchronous active-low reset loads the generator seed, clears the count,
// empties the queue and drops o_valid. When the receiver stalls, the result
// register holds, the back waits with its next result, the queue fills and
// the front in turn raises o_stall.
module prng_bit_distance_encoder_unit
    import pbde_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 32
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_call_count,
    output logic        o_last_of_byte
);

    // Front to queue: one bit command per push.
    t_bit_cmd  front_cmd;
    logic      q_push;
    // Queue to back: head bit command and fill status.
    t_bit_cmd  q_cmd;
    t_q_status q_status;
    logic      q_pop;

    // The front splits each byte into eight bit commands.
    pbde_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .i_stall_unused_guard (1'b0),
        .i_data_byte          (i_data_byte),
        .o_stall              (o_stall),
        .i_q_full             (q_status.full),
        .o_push               (q_push),
        .o_cmd                (front_cmd)
    );

    // The queue decouples byte intake from the long generator walks.
    pbde_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_cmd    (front_cmd),
        .i_pop    (q_pop),
        .o_cmd    (q_cmd),
        .o_status (q_status)
    );

    // The back replays the generator by the running count, then searches for
    // the wanted bit and registers the new count as a result.
    pbde_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_status.empty),
        .i_cmd          (q_cmd),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_call_count   (o_call_count),
        .o_last_of_byte (o_last_of_byte)
    );

`ifndef ASSERT_OFF
    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("bit queue overflow");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("bit queue underflow");

    // The fill level rises by one on a push without a pop into a queue that is not full.
    a_level_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !q_pop && !q_status.full) |=>
            (q_status.level == $past(q_status.level) + Q_LVL_W'(1)))
        else $error("bit queue level mismatch");
`endif

endmodule
